// File: rtl/csi_pkg.sv
// ----------------------------------------------------------------------------
// csi_pkg
// Shared types and constants of the constraint slack initialiser.
// ----------------------------------------------------------------------------
package csi_pkg;

  localparam int unsigned QBITS = 31;
  localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

  localparam logic [1:0] REG_BARRIER = 2'd0;
  localparam logic [1:0] REG_MINSLK  = 2'd1;
  localparam logic [1:0] REG_WARM    = 2'd2;

  typedef struct packed {
    logic [30:0] div;
    logic [30:0] rem;
    logic [30:0] num;
    logic [30:0] quo;
    logic        sat;
  } lane_t;

  typedef struct packed {
    logic signed [31:0] new_value;
    logic [30:0]        slack_low;
    logic [30:0]        slack_high;
    logic               eos;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t pay;
    lane_t lo_l;
    lane_t hi_l;
  } stage_t;

endpackage

// File: rtl/csi_if.sv
// ----------------------------------------------------------------------------
// csi_in_if / csi_out_if
// Valid/ready channels carrying constraint items and their results.
// ----------------------------------------------------------------------------
interface csi_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] value;
  logic signed [31:0] lower_bound;
  logic signed [31:0] upper_bound;
  logic               end_of_set;
  modport source (output valid, kind, value, lower_bound, upper_bound, end_of_set,
                  input ready);
  modport sink (input valid, kind, value, lower_bound, upper_bound, end_of_set,
                output ready);
endinterface

interface csi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_value;
  logic [30:0]        slack_low;
  logic [30:0]        slack_high;
  logic [30:0]        mult_low;
  logic [30:0]        mult_high;
  logic               end_of_set_out;
  modport source (output valid, new_value, slack_low, slack_high, mult_low, mult_high,
                  end_of_set_out, input ready);
  modport sink (input valid, new_value, slack_low, slack_high, mult_low, mult_high,
                end_of_set_out, output ready);
endinterface

// File: rtl/csi_front.sv
// ----------------------------------------------------------------------------
// csi_front
// Forms and repairs the slacks and the value, and seeds both divider lanes.
// ----------------------------------------------------------------------------
module csi_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic                 kind,
  input  logic signed [31:0]   value,
  input  logic signed [31:0]   lower_bound,
  input  logic signed [31:0]   upper_bound,
  input  logic                 end_of_set,
  input  logic [30:0]          barrier,
  input  logic [30:0]          min_slack,
  input  logic                 warm,
  output csi_pkg::stage_t      q_o
);
  import csi_pkg::*;

  logic signed [33:0] v, lb, ub, m, lo, hi, nv, sum;
  logic [30:0]        slo, shi;
  stage_t             st_r, st_nxt;

  function automatic logic signed [33:0] sat32(input logic signed [33:0] x);
    if (x > 34'sh0_7FFF_FFFF)       return 34'sh0_7FFF_FFFF;
    else if (x < -34'sh0_8000_0000) return -34'sh0_8000_0000;
    else                            return x;
  endfunction

  function automatic lane_t seed(input logic [30:0] b, input logic [30:0] d);
    lane_t l;
    l.div = d;
    l.rem = {15'd0, b[30:15]};
    l.num = {b[14:0], 16'd0};
    l.quo = '0;
    // The quotient overflows 31 bits exactly when barrier >> 15 reaches the slack.
    l.sat = ({15'd0, b[30:15]} >= d);
    return l;
  endfunction

  always_comb begin
    v   = warm ? 34'(value) : '0;
    lb  = 34'(lower_bound);
    ub  = 34'(upper_bound);
    m   = {3'd0, (min_slack == '0) ? 31'd1 : min_slack};
    lo  = v - lb;
    hi  = ub - v;
    nv  = v;
    sum = lb + ub;
    if (kind) begin
      if (lo < m) lo = m;
      if (hi < m) hi = m;
    end else if (lo < m) begin
      if (hi < m) begin
        nv = sum >>> 1;
        hi = m;
      end else begin
        nv = sat32(lb + m);
      end
      lo = m;
    end else if (hi < m) begin
      hi = m;
      nv = sat32(ub - m);
    end
    slo = (lo > 34'sh0_7FFF_FFFF) ? MAX31 : lo[30:0];
    shi = (hi > 34'sh0_7FFF_FFFF) ? MAX31 : hi[30:0];
    st_nxt.valid          = in_valid;
    st_nxt.pay.new_value  = nv[31:0];
    st_nxt.pay.slack_low  = slo;
    st_nxt.pay.slack_high = shi;
    st_nxt.pay.eos        = end_of_set;
    st_nxt.lo_l           = seed(barrier, slo);
    st_nxt.hi_l           = seed(barrier, shi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  assign q_o = st_r;
endmodule

// File: rtl/csi_cell.sv
// ----------------------------------------------------------------------------
// csi_cell
// One restoring division step for both lanes, registered, with the item.
// ----------------------------------------------------------------------------
module csi_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  csi_pkg::stage_t d_i,
  output csi_pkg::stage_t q_o
);
  import csi_pkg::*;

  stage_t st_r, st_nxt;

  function automatic lane_t step(input lane_t l);
    lane_t       r;
    logic [31:0] t;
    logic        ge;
    t     = {1'b0, l.rem} << 1 | {31'd0, l.num[30]};
    ge    = (t >= {1'b0, l.div});
    r     = l;
    r.rem = ge ? 31'(t - {1'b0, l.div}) : t[30:0];
    r.num = {l.num[29:0], 1'b0};
    r.quo = {l.quo[29:0], ge};
    return r;
  endfunction

  always_comb begin
    st_nxt      = d_i;
    st_nxt.lo_l = step(d_i.lo_l);
    st_nxt.hi_l = step(d_i.hi_l);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  assign q_o = st_r;
endmodule

// File: rtl/constraint_slack_initializer.sv
// ----------------------------------------------------------------------------
// constraint_slack_initializer
// Interior-point starting slacks and multipliers, one constraint per beat.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// in_ch    in   kind, value, lower_bound, upper_bound, end_of_set
// out_ch   out  new_value, slack_low, slack_high, mult_low, mult_high,
//               end_of_set_out
// cfg_*    in   write enable, index, 31-bit data
// A beat is accepted every cycle unless the output stalls. Stages: one front stage
// plus one cell for each of the 31 quotient bits of the two dividers.
// The whole row of cells advances together; a stalled output halts it.
// Synchronous reset clears the valid bits and restores the configuration registers.
module constraint_slack_initializer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  csi_in_if.sink      in_ch,
  csi_out_if.source   out_ch
);
  import csi_pkg::*;

  logic [30:0] barrier_r, min_slack_r;
  logic        warm_r;
  logic        adv;
  stage_t      st [QBITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      barrier_r   <= 31'd65536;
      min_slack_r <= 31'd6554;
      warm_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BARRIER: barrier_r   <= cfg_data;
        REG_MINSLK:  min_slack_r <= cfg_data;
        REG_WARM:    warm_r      <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  assign adv         = !st[QBITS].valid || out_ch.ready;
  assign in_ch.ready = adv;

  csi_front u_front (
    .clk, .rst_n, .en(adv), .in_valid(in_ch.valid),
    .kind(in_ch.kind), .value(in_ch.value), .lower_bound(in_ch.lower_bound),
    .upper_bound(in_ch.upper_bound), .end_of_set(in_ch.end_of_set),
    .barrier(barrier_r), .min_slack(min_slack_r), .warm(warm_r),
    .q_o(st[0])
  );

  for (genvar g = 0; g < QBITS; g++) begin : g_cell
    csi_cell u_cell (.clk, .rst_n, .en(adv), .d_i(st[g]), .q_o(st[g+1]));
  end

  assign out_ch.valid          = st[QBITS].valid;
  assign out_ch.new_value      = st[QBITS].pay.new_value;
  assign out_ch.slack_low      = st[QBITS].pay.slack_low;
  assign out_ch.slack_high     = st[QBITS].pay.slack_high;
  assign out_ch.end_of_set_out = st[QBITS].pay.eos;
  assign out_ch.mult_low  = st[QBITS].lo_l.sat ? MAX31 : st[QBITS].lo_l.quo;
  assign out_ch.mult_high = st[QBITS].hi_l.sat ? MAX31 : st[QBITS].hi_l.quo;

`ifndef SYNTHESIS
  a_slack_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.slack_low != '0 && out_ch.slack_high != '0))
    else $error("zero slack delivered");
  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == (!out_ch.valid || out_ch.ready))
    else $error("input ready out of step with output stall");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");
`endif
endmodule

// File: verif/tb_constraint_slack_initializer.sv
// ----------------------------------------------------------------------------
// tb_constraint_slack_initializer
// Self-checking bench for the slack initialiser: a directed table followed
// by random constraint items under several register settings, with random
// gaps on the input and random stalls on the output. Results are checked
// against table rows or a predictor of slacks, moved values and multipliers.
// ----------------------------------------------------------------------------
module tb_constraint_slack_initializer;
  import csi_pkg::*;

  localparam longint LMAX31 = 64'sd2147483647;
  localparam longint LMIN32 = -64'sd2147483648;
  localparam int     DRAIN = 40;
  localparam int     WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic signed [31:0] new_value;
    logic [30:0]        slack_low;
    logic [30:0]        slack_high;
    logic [30:0]        mult_low;
    logic [30:0]        mult_high;
    logic               eos;
  } slack_res_t;

  typedef struct packed {
    logic               warm;
    logic               kind;
    logic signed [31:0] value;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic               eos;
    logic               typed;
    slack_res_t         res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [30:0] cfg_data;

  csi_in_if  in_ch ();
  csi_out_if out_ch ();

  constraint_slack_initializer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bench copy of the registers.
  logic [30:0] barrier_q;
  logic [30:0] min_slack_q;
  logic        warm_q;

  slack_res_t  pending_results[$];
  logic        row_typed;
  slack_res_t  row_res;
  int          mismatches;
  int          idle_cycles;
  bit          out_quiet;
  bit          in_quiet;

  function automatic logic [30:0] barrier_quotient(longint slack);
    longint q;
    q = (longint'(barrier_q) <<< 16) / slack;
    return (q > LMAX31) ? 31'(LMAX31) : 31'(q);
  endfunction

  function automatic slack_res_t predict_slacks(logic kind, logic signed [31:0] val,
                                                logic signed [31:0] lb,
                                                logic signed [31:0] ub, logic eos);
    slack_res_t r;
    longint v, l, u, m, lo, hi, s;
    v  = warm_q ? longint'(val) : 64'sd0;
    l  = longint'(lb);
    u  = longint'(ub);
    m  = (min_slack_q == 31'd0) ? 64'sd1 : longint'(min_slack_q);
    lo = v - l;
    hi = u - v;
    if (kind) begin
      if (lo < m) lo = m;
      if (hi < m) hi = m;
    end else if (lo < m) begin
      if (hi < m) begin
        // Both slacks too tight: park the value on the rounded-down midpoint.
        s  = l + u;
        v  = (s >= 0) ? s / 2 : -((-s + 1) / 2);
        hi = m;
      end else begin
        v = l + m;
        if (v > LMAX31) v = LMAX31;
      end
      lo = m;
    end else if (hi < m) begin
      hi = m;
      v  = u - m;
      if (v < LMIN32) v = LMIN32;
    end
    if (lo > LMAX31) lo = LMAX31;
    if (hi > LMAX31) hi = LMAX31;
    r.new_value  = 32'(v);
    r.slack_low  = 31'(lo);
    r.slack_high = 31'(hi);
    r.mult_low   = barrier_quotient(lo);
    r.mult_high  = barrier_quotient(hi);
    r.eos        = eos;
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Modest Q16.16 values half of the time, else full range or an extreme.
  function automatic logic signed [31:0] rand_q16();
    int p;
    p = $urandom_range(0, 9);
    if (p < 5) return $signed(32'($urandom_range(0, 32'h0040_0000))) - 32'sh0020_0000;
    if (p < 8) return $signed($urandom());
    if (p == 8) return 32'sh7FFF_FFFF - $signed(32'($urandom_range(0, 3)));
    return 32'sh8000_0000 + $signed(32'($urandom_range(0, 3)));
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [30:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (idx)
      REG_BARRIER: barrier_q   = data;
      REG_MINSLK:  min_slack_q = data;
      default:     warm_q      = data[0];
    endcase
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic send_item(stim_row_t row);
    int g;
    g = in_quiet ? 0 : gap_len();
    repeat (g) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.kind        = row.kind;
    in_ch.value       = row.value;
    in_ch.lower_bound = row.lower_bound;
    in_ch.upper_bound = row.upper_bound;
    in_ch.end_of_set  = row.eos;
    row_typed         = row.typed;
    row_res           = row.res;
    in_ch.valid       = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Result side stalls.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_quiet) begin
        out_ch.ready = 1'b1;
      end else begin
        stall = gap_len();
        out_ch.ready = (stall == 0);
        if (stall != 0) begin
          repeat (stall - 1) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    slack_res_t got, want;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(row_typed ? row_res :
          predict_slacks(in_ch.kind, in_ch.value, in_ch.lower_bound, in_ch.upper_bound,
                         in_ch.end_of_set));
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.new_value, out_ch.slack_low, out_ch.slack_high, out_ch.mult_low,
                out_ch.mult_high, out_ch.end_of_set_out};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_constraint_slack_initializer failed");
        $finish;
      end
    end
  end

  stim_row_t directed_rows[$];

  initial begin
    stim_row_t   row;
    logic [30:0] barrier_set[6];
    logic [30:0] minslk_set[6];
    logic        warm_set[6];
    logic signed [31:0] a, b;
    int          p;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_BARRIER;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.value = '0;
    in_ch.lower_bound = '0;
    in_ch.upper_bound = '0;
    in_ch.end_of_set = 1'b0;
    row_typed = 1'b0;
    row_res = '0;
    mismatches = 0;
    idle_cycles = 0;
    out_quiet = 1'b0;
    in_quiet = 1'b0;
    barrier_q = 31'd65536;
    min_slack_q = 31'd6554;
    warm_q = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed_rows = '{
      // Cold start, reset registers: symmetric unit box gives unit slacks.
      '{1'b0, 1'b0, 32'sh1234_5678, -32'sd65536, 32'sd65536, 1'b0, 1'b1,
        '{32'sd0, 31'd65536, 31'd65536, 31'd65536, 31'd65536, 1'b0}},
      '{1'b0, 1'b1, -32'sd99, -32'sd65536, 32'sd65536, 1'b1, 1'b1,
        '{32'sd0, 31'd65536, 31'd65536, 31'd65536, 31'd65536, 1'b1}},
      // Widest box: both slacks saturate, multipliers are two.
      '{1'b0, 1'b0, 32'sd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 1'b1,
        '{32'sd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd2, 31'd2, 1'b1}},
      '{1'b0, 1'b0, 32'sd0, 32'sd65536, -32'sd65536, 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, 32'sd0, 32'sd0, 32'sh7FFF_FFFF, 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, 32'sd0, 32'sh8000_0000, 32'sd0, 1'b0, 1'b0, '0},
      '{1'b0, 1'b1, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0, '0},
      '{1'b0, 1'b1, 32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 1'b0, '0},
      // Warm start from here on.
      '{1'b1, 1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 1'b0, '0},
      '{1'b1, 1'b0, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 1'b0, '0},
      '{1'b1, 1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 1'b0, '0},
      '{1'b1, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 1'b0, '0},
      '{1'b1, 1'b0, 32'sd100, 32'sd0, 32'sd200, 1'b0, 1'b0, '0},
      '{1'b1, 1'b0, 32'sd3, -32'sd7, 32'sd8, 1'b0, 1'b0, '0},
      '{1'b1, 1'b0, -32'sd5, 32'sd4, -32'sd7, 1'b1, 1'b0, '0},
      '{1'b1, 1'b1, 32'sd65536, 32'sd0, 32'sd131072, 1'b0, 1'b0, '0}
    };

    foreach (directed_rows[i]) begin
      if (directed_rows[i].warm != warm_q) begin
        in_ch.valid = 1'b0;
        wait_idle();
        write_reg(REG_WARM, 31'(directed_rows[i].warm));
      end
      send_item(directed_rows[i]);
    end
    in_ch.valid = 1'b0;
    row_typed = 1'b0;

    // Register settings for the random phases, extremes included.
    barrier_set = '{31'd65536, 31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'($urandom()), 31'd1};
    minslk_set  = '{31'd6554, 31'd0, 31'h7FFF_FFFF, 31'd1, 31'($urandom_range(1, 1 << 20)),
                    31'h4000_0000};
    warm_set    = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_reg(REG_BARRIER, barrier_set[ph]);
      write_reg(REG_MINSLK, minslk_set[ph]);
      write_reg(REG_WARM, 31'(warm_set[ph]));
      in_quiet  = (ph == 2);
      out_quiet = (ph == 3);
      for (int n = 0; n < 180; n++) begin
        row = '0;
        row.kind = 1'($urandom_range(0, 1));
        row.eos  = ($urandom_range(0, 7) == 0);
        p = $urandom_range(0, 9);
        a = rand_q16();
        b = rand_q16();
        if (p < 7) begin
          // Well-formed box with the value near a bound or anywhere inside.
          row.lower_bound = (a < b) ? a : b;
          row.upper_bound = (a < b) ? b : a;
          case ($urandom_range(0, 3))
            0: row.value = row.lower_bound + $signed(32'($urandom_range(0, 8)));
            1: row.value = row.upper_bound - $signed(32'($urandom_range(0, 8)));
            default: row.value = row.lower_bound
                                 + $signed(32'($urandom_range(0, 32'(row.upper_bound
                                                                     - row.lower_bound))));
          endcase
        end else begin
          row.lower_bound = a;
          row.upper_bound = b;
          row.value = rand_q16();
        end
        send_item(row);
      end
      in_ch.valid = 1'b0;
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_constraint_slack_initializer passed");
    end else begin
      $display("tb_constraint_slack_initializer failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/csi_pkg.sv
rtl/csi_if.sv
rtl/csi_front.sv
rtl/csi_cell.sv
rtl/constraint_slack_initializer.sv
verif/tb_constraint_slack_initializer.sv
